// File: design/rpds_pkg.sv
// Package for the RGB pixel distance similarity block.
// Holds word types, widths, constants and the controller/datapath command types.
// Depends on nothing; every design file imports it.
package rpds_pkg;

    // Image limits and similarity format
    localparam int MAX_DIMENSION = 2048;
    localparam int SIM_FRAC_BITS = 16;

    // Field widths
    localparam int CHAN_W   = 8;
    localparam int DIM_W    = 12;
    localparam int SUM_W    = 31;
    localparam int CNT_W    = 23;
    localparam int SIM_W    = 17;
    localparam int NPIX_W   = 2 * DIM_W;
    localparam int KQ_W     = 25;
    localparam int DEN_W    = KQ_W + NPIX_W;
    localparam int REM_W    = DEN_W + 1;
    localparam int SQ_W     = 18;
    localparam int ROOT_W   = 19;
    localparam int DIST_W   = 9;
    localparam int DIVC_W   = (SIM_FRAC_BITS > 1) ? $clog2(SIM_FRAC_BITS) : 1;
    localparam int CFG_IDX_W = 1;

    // sqrt(3)*255 scaled by 2^16, rounded to nearest
    localparam logic [KQ_W-1:0]   KQ16      = KQ_W'(28945479);
    localparam logic [SUM_W-1:0]  SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [ROOT_W-1:0] ROOT_TOP  = ROOT_W'(1) << (ROOT_W - 1);
    localparam logic [DIM_W-1:0]  DIM_RESET = DIM_W'(256);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    typedef struct packed {
        logic [CHAN_W-1:0] ref_blue;
        logic [CHAN_W-1:0] ref_green;
        logic [CHAN_W-1:0] ref_red;
        logic [CHAN_W-1:0] cand_blue;
        logic [CHAN_W-1:0] cand_green;
        logic [CHAN_W-1:0] cand_red;
        logic              final_pixel;
    } t_in_word;

    typedef struct packed {
        logic [SUM_W-1:0] total_distance;
        logic [SIM_W-1:0] similarity_q16;
        logic             size_mismatch;
    } t_out_word;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic square;
        logic root_step;
        logic accum;
        logic area;
        logic scale;
        logic check;
        logic div_step;
        logic deliver;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic final_pixel;
        logic root_last;
        logic early_zero;
        logic div_last;
    } t_dp_stat;

endpackage

// File: design/rpds_dp.sv
// Datapath of the RGB pixel distance similarity block: config registers,
// bit-serial square root, saturating totals, restoring divider, output word.
// Depends on rpds_pkg; driven by rpds_ctrl through t_dp_cmd.
module rpds_dp
    import rpds_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data,
    input  t_in_word             i_data,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    output t_out_word            o_data
);

    logic [DIM_W-1:0]  r_width;
    logic [DIM_W-1:0]  r_height;
    logic [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_count;
    logic [CHAN_W-1:0] r_db, r_dg, r_dr;
    logic              r_final;
    logic [SQ_W-1:0]   r_v;
    logic [ROOT_W-1:0] r_root;
    logic [ROOT_W-1:0] r_bit;
    logic [NPIX_W-1:0] r_npix;
    logic [DEN_W-1:0]  r_den;
    logic              r_mismatch;
    logic              r_zero;
    logic [REM_W-1:0]  r_rem;
    logic [SIM_FRAC_BITS-1:0] r_q;
    logic [DIVC_W-1:0] r_div_cnt;
    t_out_word         r_out;

    logic [ROOT_W:0]   trial;
    logic              root_take;
    logic [SUM_W:0]    sum_ext;
    logic [REM_W-1:0]  rem_init;
    logic [REM_W-1:0]  rem_shift;
    logic [REM_W-1:0]  den_ext;
    logic              div_take;
    logic              dims_ok;
    logic [SIM_FRAC_BITS:0] q_ceil;
    logic [31:0]       sim_full;

    function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

    // One step of the digit-by-digit square root
    assign trial     = {1'b0, r_root} + {1'b0, r_bit};
    assign root_take = {{(ROOT_W + 1 - SQ_W){1'b0}}, r_v} >= trial;

    // Saturating sum with the finished root
    assign sum_ext = {1'b0, r_sum} + (SUM_W + 1)'(r_root[DIST_W-1:0]);

    // Divider: remainder starts at total * 2^16
    assign rem_init  = REM_W'({r_sum, 16'b0});
    assign den_ext   = {1'b0, r_den};
    assign rem_shift = {r_rem[REM_W-2:0], 1'b0};
    assign div_take  = rem_shift >= den_ext;

    assign dims_ok = (r_width != '0) && (32'(r_width) <= 32'(MAX_DIMENSION))
                  && (r_height != '0) && (32'(r_height) <= 32'(MAX_DIMENSION));

    // Round the quotient up, then take it from one
    assign q_ceil   = {1'b0, r_q} + (SIM_FRAC_BITS + 1)'(r_rem != '0);
    assign sim_full = (r_zero || q_ceil[SIM_FRAC_BITS]) ? 32'd0
                    : 32'((32'd1 << SIM_FRAC_BITS) - 32'(q_ceil));

    assign o_stat.final_pixel = r_final;
    assign o_stat.root_last   = r_bit[0];
    assign o_stat.early_zero  = r_mismatch || (rem_init >= den_ext);
    assign o_stat.div_last    = (r_div_cnt == DIVC_W'(SIM_FRAC_BITS - 1));
    assign o_data = r_out;

    // Control state: config registers and running totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_RESET;
            r_height <= DIM_RESET;
            r_sum    <= '0;
            r_count  <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_IMAGE_WIDTH) begin
                    r_width <= i_cfg_data;
                end
                if (i_cfg_index == CFG_IMAGE_HEIGHT) begin
                    r_height <= i_cfg_data;
                end
            end
            if (i_cmd.accum) begin
                r_sum <= (sum_ext > {1'b0, SUM_MAX}) ? SUM_MAX : sum_ext[SUM_W-1:0];
                if (r_count != COUNT_MAX) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end else if (i_cmd.deliver) begin
                r_sum   <= '0;
                r_count <= '0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        // Capture channel differences
        if (i_cmd.load_in) begin
            r_db    <= abs_diff(i_data.ref_blue, i_data.cand_blue);
            r_dg    <= abs_diff(i_data.ref_green, i_data.cand_green);
            r_dr    <= abs_diff(i_data.ref_red, i_data.cand_red);
            r_final <= i_data.final_pixel;
        end
        // Sum of squares, start the root
        if (i_cmd.square) begin
            r_v    <= SQ_W'(r_db) * SQ_W'(r_db) + SQ_W'(r_dg) * SQ_W'(r_dg)
                    + SQ_W'(r_dr) * SQ_W'(r_dr);
            r_root <= '0;
            r_bit  <= ROOT_TOP;
        end
        if (i_cmd.root_step) begin
            if (root_take) begin
                r_v    <= r_v - trial[SQ_W-1:0];
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        // Pixel count of the image
        if (i_cmd.area) begin
            r_npix <= NPIX_W'(r_width) * NPIX_W'(r_height);
        end
        if (i_cmd.scale) begin
            r_den      <= DEN_W'(KQ16) * DEN_W'(r_npix);
            r_mismatch <= !dims_ok || ({{(NPIX_W - CNT_W){1'b0}}, r_count} != r_npix);
        end
        if (i_cmd.check) begin
            r_rem     <= rem_init;
            r_q       <= '0;
            r_zero    <= o_stat.early_zero;
            r_div_cnt <= '0;
        end
        // One quotient bit a cycle
        if (i_cmd.div_step) begin
            r_rem     <= div_take ? (rem_shift - den_ext) : rem_shift;
            r_q       <= {r_q[SIM_FRAC_BITS-2:0], div_take};
            r_div_cnt <= r_div_cnt + DIVC_W'(1);
        end
        if (i_cmd.deliver) begin
            r_out.total_distance <= r_sum;
            r_out.similarity_q16 <= sim_full[SIM_W-1:0];
            r_out.size_mismatch  <= r_mismatch;
        end
    end

endmodule

// File: design/rpds_ctrl.sv
// Controller of the RGB pixel distance similarity block: sequences the
// per-pixel root and the end-of-image division, and owns the output valid.
// Depends on rpds_pkg; drives rpds_dp through t_dp_cmd.
module rpds_ctrl
    import rpds_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    output logic     o_valid,
    input  logic     i_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQUARE,
        S_ROOT,
        S_ACCUM,
        S_AREA,
        S_SCALE,
        S_CHECK,
        S_DIVIDE,
        S_DELIVER
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;

    // Next state and datapath commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_stall;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_SQUARE;
                end
            end
            S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (i_stat.root_last) begin
                    n_state = S_ACCUM;
                end
            end
            S_ACCUM: begin
                o_cmd.accum = 1'b1;
                n_state     = i_stat.final_pixel ? S_AREA : S_IDLE;
            end
            S_AREA: begin
                o_cmd.area = 1'b1;
                n_state    = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_stat.early_zero ? S_DELIVER : S_DIVIDE;
            end
            S_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_DELIVER;
                end
            end
            S_DELIVER: begin
                // Hold until the output register is free
                if (out_free) begin
                    o_cmd.deliver = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: design/rgb_pixel_distance_similarity.sv
// Sum of Euclidean RGB pixel distances with a similarity score. Each input
// word carries a reference and a candidate pixel; the block adds the floor of
// their RGB distance to a saturating total and counts pixels. The word marked
// final_pixel yields one output word with the total, the similarity
// 1 - total/(sqrt(3)*255*width*height) in unsigned Q1.16 (floored, clamped at
// zero) and a size mismatch flag; both totals are then cleared. Each pixel
// passes through the square root unit, which resolves one result bit per
// cycle over ten steps, before the next pixel is accepted. The final pixel
// then runs the restoring divider, which yields one quotient bit per cycle;
// when the size check fails or the total alone rules out a nonzero score
// the divider is skipped. A stalled output word holds the next final result,
// and with it the input, until it is taken.
// A finished word waits in the output register while the next pixel
// is taken. Write image_width and image_height only while the block is idle.
module rgb_pixel_distance_similarity
    import rpds_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_in_word             i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_out_word            o_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    rpds_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    rpds_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_data      (i_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_data      (o_data)
    );

endmodule
